[sv/aes_pkg.sv]
`default_nettype none
package aes_pkg;

    localparam int KeyHalfW = 64;
    localparam int BlockW = 128;
    localparam int NumRounds = 10;
    localparam int RoundW = 4;
    localparam int CfgIndexW = 2;

    localparam logic [CfgIndexW-1:0] CFG_KEY_LOW = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } aes_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] o;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[32*c +: 8];
            a1 = s[32*c+8 +: 8];
            a2 = s[32*c+16 +: 8];
            a3 = s[32*c+24 +: 8];
            o[32*c +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[32*c+8 +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return o;
    endfunction

    function automatic logic [BlockW-1:0] key_step(input logic [BlockW-1:0] k,
                                                   input logic [7:0] rcon);
        logic [BlockW-1:0] n;
        logic [31:0] t;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rcon};
        n[31:0] = k[31:0] ^ t;
        n[63:32] = k[63:32] ^ n[31:0];
        n[95:64] = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

endpackage
`default_nettype wire

[sv/aes_ctrl.sv]
`default_nettype none
module aes_ctrl
    import aes_pkg::*;
#(
    parameter int NUM_ROUNDS = NumRounds
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output aes_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN = 1'b1;

    logic state_reg, state_next;
    logic [RoundW-1:0] round_reg, round_next;
    logic out_valid_reg, out_valid_next;
    logic last;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign last = (round_reg == RoundW'(NUM_ROUNDS));

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.last = last;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    round_next = RoundW'(1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!last || !out_valid_reg || out_ready)
                begin
                    cmd.step = 1'b1;
                    round_next = round_reg + RoundW'(1);
                    if (last)
                    begin
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[sv/aes_dp.sv]
`default_nettype none
module aes_dp
    import aes_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [KeyHalfW-1:0]  cfg_data,
    input  wire logic [KeyHalfW-1:0]  block_low,
    input  wire logic [KeyHalfW-1:0]  block_high,
    input  wire aes_cmd_t             cmd,
    output logic [KeyHalfW-1:0]       cipher_low,
    output logic [KeyHalfW-1:0]       cipher_high
);

    logic [KeyHalfW-1:0] key_low_reg, key_high_reg;
    logic [BlockW-1:0] state_reg, rkey_reg, out_reg;
    logic [7:0] rcon_reg;
    logic [BlockW-1:0] rkey_next, sub_out, round_out;

    assign rkey_next = key_step(rkey_reg, rcon_reg);
    assign sub_out = sub_shift(state_reg);
    assign round_out = (cmd.last ? sub_out : mix_columns(sub_out)) ^ rkey_next;
    assign cipher_low = out_reg[KeyHalfW-1:0];
    assign cipher_high = out_reg[BlockW-1:KeyHalfW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            state_reg <= {block_high, block_low} ^ {key_high_reg, key_low_reg};
            rkey_reg <= {key_high_reg, key_low_reg};
            rcon_reg <= RCON_FIRST;
        end
        else if (cmd.step)
        begin
            state_reg <= round_out;
            rkey_reg <= rkey_next;
            rcon_reg <= xtime(rcon_reg);
        end
        if (cmd.step && cmd.last)
        begin
            out_reg <= round_out;
        end
    end

endmodule
`default_nettype wire

[sv/aes128_block_encrypt_core.sv]
`default_nettype none
// Ciphertext path: the accepting edge loads the block with the first key addition,
// then the rounds run one after another on the shared round unit, with round keys
// derived on the fly; the last round stalls while an earlier ciphertext is unread.
// A new request is taken only when the engine is idle; it is taken while the
// previous ciphertext waits in the output register.
// Reset clears the key to zero and empties the engine and output register.
module aes128_block_encrypt_core
    import aes_pkg::*;
#(
    parameter int NUM_ROUNDS = NumRounds
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [KeyHalfW-1:0]  cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [KeyHalfW-1:0]  block_low,
    input  wire logic [KeyHalfW-1:0]  block_high,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KeyHalfW-1:0]       cipher_low,
    output logic [KeyHalfW-1:0]       cipher_high
);

    aes_cmd_t cmd;

    aes_ctrl #(
        .NUM_ROUNDS(NUM_ROUNDS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd(cmd)
    );

    aes_dp u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .block_low(block_low),
        .block_high(block_high),
        .cmd(cmd),
        .cipher_low(cipher_low),
        .cipher_high(cipher_high)
    );

endmodule
`default_nettype wire

[verif/aes128_block_encrypt_core_tb.sv]
`default_nettype none
module aes128_block_encrypt_core_tb;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [127:0] block_t;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        inv = 8'h01;
        base = x;
        for (int e = 0; e < 8; e++)
        begin
            if (e != 0)
                inv = gf_product(inv, base);
            base = gf_product(base, base);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    class cipher_scoreboard;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        block_t round_keys [11];
        block_t pending [$];
        int errors;

        function new();
            key_lo = '0;
            key_hi = '0;
            errors = 0;
            expand();
        endfunction

        function void expand();
            logic [7:0] w [176];
            logic [7:0] t [4];
            logic [7:0] rc;
            logic [7:0] tmp;
            block_t k;
            k = {key_hi, key_lo};
            rc = 8'h01;
            for (int i = 0; i < 16; i++)
                w[i] = k[8*i +: 8];
            for (int i = 4; i < 44; i++)
            begin
                for (int j = 0; j < 4; j++)
                    t[j] = w[4*(i-1)+j];
                if (i % 4 == 0)
                begin
                    tmp = t[0];
                    t[0] = sub_byte(t[1]) ^ rc;
                    t[1] = sub_byte(t[2]);
                    t[2] = sub_byte(t[3]);
                    t[3] = sub_byte(tmp);
                    rc = gf_double(rc);
                end
                for (int j = 0; j < 4; j++)
                    w[4*i+j] = w[4*(i-4)+j] ^ t[j];
            end
            for (int r = 0; r < 11; r++)
                for (int i = 0; i < 16; i++)
                    round_keys[r][8*i +: 8] = w[16*r+i];
        endfunction

        function void write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] v);
            if (idx == CFG_KEY_LOW)
                key_lo = v;
            else if (idx == CFG_KEY_HIGH)
                key_hi = v;
            else
                return;
            expand();
        endfunction

        function block_t encrypt(input block_t p);
            block_t s;
            block_t o;
            logic [7:0] a0, a1, a2, a3;
            s = p ^ round_keys[0];
            for (int r = 1; r <= 10; r++)
            begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        o[8*(w+4*c) +: 8] = sub_byte(s[8*(w+4*((c+w)%4)) +: 8]);
                s = o;
                if (r < 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[32*c +: 8];
                        a1 = s[32*c+8 +: 8];
                        a2 = s[32*c+16 +: 8];
                        a3 = s[32*c+24 +: 8];
                        o[32*c +: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                        o[32*c+8 +: 8] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                        o[32*c+16 +: 8] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                        o[32*c+24 +: 8] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                    end
                    s = o;
                end
                s ^= round_keys[r];
            end
            return s;
        endfunction

        function void note_request(input logic [63:0] lo, input logic [63:0] hi);
            pending.push_back(encrypt({hi, lo}));
        endfunction

        function void check_cipher(input logic [63:0] lo, input logic [63:0] hi);
            block_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected cipher %h %h", $time, hi, lo);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (lo !== want[63:0])
            begin
                $display("%0t: cipher_low expected %h actual %h", $time, want[63:0], lo);
                errors++;
            end
            if (hi !== want[127:64])
            begin
                $display("%0t: cipher_high expected %h actual %h", $time, want[127:64], hi);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [KeyHalfW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [KeyHalfW-1:0] block_low = '0;
    logic [KeyHalfW-1:0] block_high = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [KeyHalfW-1:0] cipher_low;
    logic [KeyHalfW-1:0] cipher_high;

    cipher_scoreboard board = new();
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_recv = 1'b0;
    longint cycles = 0;

    aes128_block_encrypt_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .block_low(block_low), .block_high(block_high), .out_valid(out_valid),
        .out_ready(out_ready), .cipher_low(cipher_low), .cipher_high(cipher_high)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_cipher(cipher_low, cipher_high);
        out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_key(input logic [CfgIndexW-1:0] idx, input logic [63:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        block_low <= lo;
        block_high <= hi;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(lo, hi);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        logic [63:0] keys [6];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h7766554433221100, 64'hffeeddccbbaa9988);
        drain();
        write_key(CFG_KEY_LOW, 64'h0706050403020100);
        drain();
        send_block(64'h7766554433221100, 64'hffeeddccbbaa9988);
        drain();
        write_key(CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        write_key(2'd2, '1);
        write_key(2'd3, 64'h1234);
        send_block(64'h7766554433221100, 64'hffeeddccbbaa9988);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain();
        write_key(CFG_KEY_LOW, '1);
        write_key(CFG_KEY_HIGH, '1);
        send_block('0, '0);
        send_block('1, '1);
        hold_recv = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_block(rand64(), rand64());
            end
            begin
                repeat (200) @(posedge clk);
                hold_recv = 1'b0;
            end
        join
        drain();
        keys[0] = '0; keys[1] = '1; keys[2] = rand64();
        keys[3] = rand64(); keys[4] = rand64(); keys[5] = rand64();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 37 : (ph == 1) ? 88 : 0;
            recv_idle = (ph == 0) ? 88 : (ph == 1) ? 37 : 0;
            for (int k = 0; k < 3; k++)
            begin
                write_key(CFG_KEY_LOW, keys[(2*k+ph) % 6]);
                write_key(CFG_KEY_HIGH, keys[(2*k+ph+1) % 6]);
                for (int i = 0; i < 190; i++)
                    send_block(rand64(), rand64());
                drain();
            end
        end
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
sv/aes_pkg.sv
sv/aes_ctrl.sv
sv/aes_dp.sv
sv/aes128_block_encrypt_core.sv
verif/aes128_block_encrypt_core_tb.sv
